>>> design/fhcu_pkg.sv
// Shared types, constants and palette for the fire heat cell update block.
`default_nettype none
package fhcu_pkg;

	localparam int GRID_WIDTH_DEF  = 256;
	localparam int GRID_HEIGHT_DEF = 64;
	localparam int HEAT_LEVELS_DEF = 37;

	localparam int HEAT_W  = 6;
	localparam int ROW_W   = 6;
	localparam int COL_W   = 8;
	localparam int COLOR_W = 24;

	// source row modes
	localparam logic [1:0] MODE_UNLIT = 2'd0;
	localparam logic [1:0] MODE_LIT   = 2'd1;

	// spread picks
	localparam logic [1:0] SPREAD_LEFT  = 2'd0;
	localparam logic [1:0] SPREAD_RIGHT = 2'd1;

	localparam logic COOL_ON   = 1'b0;
	localparam logic IGNITE_ON = 1'b0;

	typedef struct packed {
		logic [1:0] flame_mode;
		logic [1:0] spread_draw;
		logic       cool_draw;
		logic       ignite_draw;
	} fhcu_in_t;

	typedef struct packed {
		logic [ROW_W-1:0]   cell_row;
		logic [COL_W-1:0]   cell_column;
		logic [HEAT_W-1:0]  heat;
		logic [COLOR_W-1:0] color;
		logic               frame_last;
	} fhcu_out_t;

	// Palette lookup; heats past the end of the ramp show white.
	function automatic logic [COLOR_W-1:0] heat_colour(input logic [HEAT_W-1:0] h);
		logic [COLOR_W-1:0] c;
		case (h)
			6'd0:  c = 24'h000000;
			6'd1:  c = 24'h070707;
			6'd2:  c = 24'h1F0707;
			6'd3:  c = 24'h2F0F07;
			6'd4:  c = 24'h470F07;
			6'd5:  c = 24'h571707;
			6'd6:  c = 24'h671F07;
			6'd7:  c = 24'h771F07;
			6'd8:  c = 24'h8F2707;
			6'd9:  c = 24'h9F2F07;
			6'd10: c = 24'hAF3F07;
			6'd11: c = 24'hBF4707;
			6'd12: c = 24'hC74707;
			6'd13: c = 24'hDF4F07;
			6'd14: c = 24'hDF5707;
			6'd15: c = 24'hDF5707;
			6'd16: c = 24'hD75F07;
			6'd17: c = 24'hD75F07;
			6'd18: c = 24'hD7670F;
			6'd19: c = 24'hCF6F0F;
			6'd20: c = 24'hCF770F;
			6'd21: c = 24'hCF7F0F;
			6'd22: c = 24'hCF8717;
			6'd23: c = 24'hC78717;
			6'd24: c = 24'hC78F17;
			6'd25: c = 24'hC7971F;
			6'd26: c = 24'hBF9F1F;
			6'd27: c = 24'hBF9F1F;
			6'd28: c = 24'hBFA727;
			6'd29: c = 24'hBFA727;
			6'd30: c = 24'hBFAF2F;
			6'd31: c = 24'hB7AF2F;
			6'd32: c = 24'hB7B72F;
			6'd33: c = 24'hB7B737;
			6'd34: c = 24'hCFCF6F;
			6'd35: c = 24'hDFDF9F;
			6'd36: c = 24'hEFEFC7;
			default: c = 24'hFFFFFF;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

>>> design/fhcu_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none
module fhcu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> design/fire_heat_cell_update.sv
// Fire heat grid updater: one cell per beat, heat held in a single RAM.
// Each input beat passes through stage 1, which holds the RAM read, and then
// the output register, which holds the finished cell.
// Throughput: one cell per cycle when not stalled or clearing; one RAM read and write per cell.
// Reset: a clearing pass writes zero to every RAM word before the first input beat is taken,
// covering all GRID_HEIGHT * 2**clog2(GRID_WIDTH) words (16384 at the default grid size).
// Scan position resets to the bottom-right cell.
`default_nettype none
module fire_heat_cell_update
	import fhcu_pkg::*;
#(
	parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT = GRID_HEIGHT_DEF,
	parameter int HEAT_LEVELS = HEAT_LEVELS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire fhcu_in_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output fhcu_out_t      out_data
);

	localparam int CW        = $clog2(GRID_WIDTH);
	localparam int RW        = $clog2(GRID_HEIGHT);
	localparam int MEM_DEPTH = GRID_HEIGHT * (1 << CW);
	localparam int AW        = $clog2(MEM_DEPTH);
	localparam logic [CW-1:0] COL_LAST = CW'(GRID_WIDTH - 1);
	localparam logic [RW-1:0] ROW_LAST = RW'(GRID_HEIGHT - 1);
	localparam logic [AW-1:0] ADDR_LAST = AW'(MEM_DEPTH - 1);
	localparam logic [HEAT_W-1:0] HEAT_MAX = HEAT_W'(HEAT_LEVELS - 1);

	// Scan position of the next cell to be taken
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;

	// Clearing pass after reset
	logic          clr_q;
	logic [AW-1:0] clr_addr_q;

	// Stage 1: RAM read in flight, cell info carried alongside
	logic          valid_s1;
	logic [RW-1:0] row_s1;
	logic [CW-1:0] col_s1;
	logic          bottom_s1;
	logic [1:0]    mode_s1;
	logic          cool_s1;
	logic          ignite_s1;

	// Output register
	logic      out_valid_q;
	fhcu_out_t out_data_q;

	logic              in_fire;
	logic              adv_s1;
	logic              fire_s1;
	logic              bottom;
	logic [CW-1:0]     src_col;
	logic [RW-1:0]     src_row;
	logic [AW-1:0]     rd_addr;
	logic [HEAT_W-1:0] rd_heat;
	logic [HEAT_W-1:0] new_heat;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [HEAT_W-1:0] ram_wdata;

	// Stage 1 moves on whenever the output register is free or being drained;
	// the next beat is taken in the same cycle, so the pipe keeps one beat per cycle
	// while results drain. A held result with stage 1 full stops input.
	assign adv_s1   = !out_valid_q || out_ready;
	assign fire_s1  = valid_s1 && adv_s1;
	assign in_ready = !clr_q && (!valid_s1 || adv_s1);
	assign in_fire  = in_valid && in_ready;

	// Source cell in the row below. At the edges only spread 0 moves, and only inward.
	assign bottom = (row_q == ROW_LAST);

	always_comb begin
		src_col = col_q;
		if (col_q == '0) begin
			if (in_data.spread_draw == SPREAD_LEFT) begin
				src_col = col_q + CW'(1);
			end
		end else if (col_q == COL_LAST) begin
			if (in_data.spread_draw == SPREAD_LEFT) begin
				src_col = col_q - CW'(1);
			end
		end else begin
			if (in_data.spread_draw == SPREAD_LEFT) begin
				src_col = col_q - CW'(1);
			end else if (in_data.spread_draw == SPREAD_RIGHT) begin
				src_col = col_q + CW'(1);
			end
		end
	end

	// The bottom row reads its own cell; other rows read the row below.
	assign src_row = bottom ? row_q : row_q + RW'(1);
	assign rd_addr = {src_row, bottom ? col_q : src_col};

	// The read only fires on an accepted beat, so rd_heat holds while stage 1 stalls.
	// A cell is never read within two beats of its write (row below, or its own
	// cell a full pass ago), so no forwarding path is needed.
	fhcu_ram #(
		.WIDTH(HEAT_W),
		.DEPTH(MEM_DEPTH)
	) u_heat_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (in_fire),
		.raddr(rd_addr),
		.rdata(rd_heat)
	);

	// New heat: source row takes the mode on ignite, else holds; other rows copy, maybe cool by one.
	always_comb begin
		new_heat = rd_heat;
		if (bottom_s1) begin
			if (ignite_s1 == IGNITE_ON) begin
				if (mode_s1 == MODE_UNLIT) begin
					new_heat = '0;
				end else if (mode_s1 == MODE_LIT) begin
					new_heat = HEAT_MAX;
				end
			end
		end else if (cool_s1 == COOL_ON && rd_heat != '0) begin
			new_heat = rd_heat - HEAT_W'(1);
		end
	end

	// Write port: clearing pass owns it until done, then stage 1 writes back.
	assign ram_we    = clr_q || fire_s1;
	assign ram_waddr = clr_q ? clr_addr_q : {row_s1, col_s1};
	assign ram_wdata = clr_q ? '0 : new_heat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= 1'b1;
			clr_addr_q  <= '0;
			row_q       <= ROW_LAST;
			col_q       <= COL_LAST;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				if (clr_addr_q == ADDR_LAST) begin
					clr_q <= 1'b0;
				end
			end

			if (in_fire) begin
				if (col_q == '0) begin
					col_q <= COL_LAST;
					row_q <= (row_q == '0) ? ROW_LAST : row_q - RW'(1);
				end else begin
					col_q <= col_q - CW'(1);
				end
			end

			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end

			if (adv_s1) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// Payload registers, no reset
	always_ff @(posedge clk) begin
		if (in_fire) begin
			row_s1    <= row_q;
			col_s1    <= col_q;
			bottom_s1 <= bottom;
			mode_s1   <= in_data.flame_mode;
			cool_s1   <= in_data.cool_draw;
			ignite_s1 <= in_data.ignite_draw;
		end
		if (fire_s1) begin
			out_data_q.cell_row    <= ROW_W'(row_s1);
			out_data_q.cell_column <= COL_W'(col_s1);
			out_data_q.heat        <= new_heat;
			out_data_q.color       <= heat_colour(new_heat);
			out_data_q.frame_last  <= (row_s1 == '0) && (col_s1 == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// No beat is taken during the clearing pass
	a_no_take_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !in_ready)
		else $error("input taken during clearing pass");

	// Read data must hold while stage 1 waits on the output
	a_rd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> $stable(rd_heat))
		else $error("RAM read data changed under a stalled cell");

	// Scan wraps from the top-left cell to the bottom-right cell
	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && row_q == '0 && col_q == '0 |=> row_q == ROW_LAST && col_q == COL_LAST)
		else $error("scan did not wrap to the bottom-right cell");

	// An accepted beat always reaches stage 1
	a_take_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> valid_s1)
		else $error("accepted beat lost before stage 1");

endmodule
`default_nettype wire
